>>> design/assert_macros.svh
// shared assertion macros for the scanner checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MBPS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scanner port check failed");

// antecedent in one cycle implies consequent in the next
`define MBPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner port sequence check failed");

`endif

>>> design/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

    // bytes that the pattern registers can hold
    localparam int PAT_BYTES = 16;
    localparam int ADDR_W    = 64;

    // register indexes on the configuration port
    localparam logic [2:0] REG_PAT_LO  = 3'd0;
    localparam logic [2:0] REG_PAT_HI  = 3'd1;
    localparam logic [2:0] REG_CARE    = 3'd2;
    localparam logic [2:0] REG_LENGTH  = 3'd3;
    localparam logic [2:0] REG_BASE    = 3'd4;

    localparam logic [63:0] PAT_RESET    = 64'h0;
    localparam logic [15:0] CARE_RESET   = 16'hFFFF;
    localparam logic [4:0]  LENGTH_RESET = 5'd1;
    localparam logic [63:0] BASE_RESET   = 64'h0;

    typedef struct packed {
        logic [8*PAT_BYTES-1:0] bytes;
        logic [PAT_BYTES-1:0]   care;
    } pattern_cfg_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] address;
    } result_t;

    // compare pattern position j against byte d; positions past the registers are wildcards
    function automatic logic pos_ok(input pattern_cfg_t cfg, input logic [3:0] j,
                                    input logic beyond, input logic [7:0] d);
        logic [7:0] p;
        p = cfg.bytes[8*j +: 8];
        return beyond || !cfg.care[j] || (p == d);
    endfunction

endpackage

`default_nettype wire

>>> design/mbps_cell.sv
`default_nettype none

module mbps_cell #(
    parameter int K  = 0,
    parameter int CW = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  shift_en,
    input  logic                  clear_en,
    input  logic [7:0]            byte_in,
    input  mbps_pkg::pattern_cfg_t cfg,
    input  logic [CW-1:0]         len_m1,
    output logic [7:0]            byte_out,
    output logic                  ok
);
    import mbps_pkg::*;

    logic [7:0]    byte_reg;
    logic [7:0]    byte_next;
    logic [CW-1:0] pat_idx;
    logic          beyond;
    logic          in_use;

    // this cell holds the byte taken K+1 transfers ago
    always_comb
    begin
        byte_next = byte_reg;
        if (clear_en)
        begin
            byte_next = 8'h00;
        end
        else if (shift_en)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign in_use  = CW'(K) < len_m1;
    assign pat_idx = len_m1 - CW'(K) - CW'(1);
    assign beyond  = pat_idx >= CW'(PAT_BYTES);

    assign ok       = !in_use || pos_ok(cfg, pat_idx[3:0], beyond, byte_reg);
    assign byte_out = byte_reg;

endmodule

`default_nettype wire

>>> design/mbps_out_buf.sv
`default_nettype none

module mbps_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbps_pkg::result_t push_data,
    output logic              full,
    output logic              result_valid,
    input  logic              result_stall,
    output mbps_pkg::result_t head
);
    import mbps_pkg::*;

    logic    v0_reg, v0_next;
    logic    v1_reg, v1_next;
    result_t e0_reg, e0_next;
    result_t e1_reg, e1_next;
    logic    pop;

    assign pop = v0_reg && !result_stall;

    // two entries so a new transfer is taken while the head waits
    always_comb
    begin
        v0_next = v0_reg;
        v1_next = v1_reg;
        e0_next = e0_reg;
        e1_next = e1_reg;
        if (pop)
        begin
            if (v1_reg)
            begin
                e0_next = e1_reg;
                v1_next = 1'b0;
            end
            else if (push)
            begin
                e0_next = push_data;
            end
            else
            begin
                v0_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!v0_reg)
            begin
                e0_next = push_data;
                v0_next = 1'b1;
            end
            else
            begin
                e1_next = push_data;
                v1_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e0_reg <= e0_next;
        e1_reg <= e1_next;
    end

    assign full         = v1_reg;
    assign result_valid = v0_reg;
    assign head         = e0_reg;

endmodule

`default_nettype wire

>>> design/masked_byte_pattern_scanner_top.sv
// masked byte pattern scanner
// bytes of a region enter on byte_value with region_end marking the last one; a
// transfer happens when byte_valid is high and byte_stall is low. one byte is
// taken every cycle while byte_stall is low: the window is a row of byte cells
// that shift together and compare against the pattern in parallel.
// at most one result per region leaves on found / match_address under
// result_valid and result_stall: found=1 with the address of the first match,
// or found=0 (address zero) when the region ends without one. a result is
// registered in the output buffer and shows on result_valid behind any older one.
// a two-entry output buffer lets bytes keep flowing while a result waits;
// byte_stall rises only once both entries hold results the receiver has not
// taken. pattern, care mask, length and region base sit on the apb port at
// byte addresses 8*i; write them only between regions or between transfers.
// reset clears the window, offset and match flag, empties the output buffer
// and loads pattern 0, care mask all ones, length 1 and base 0.
// every region end clears the window, offset and match flag.
`default_nettype none

module masked_byte_pattern_scanner_top #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        region_end,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        found,
    output logic [63:0] match_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mbps_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW    = (LEN_W > 5) ? LEN_W : 5;
    localparam int NCELL = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

    logic [63:0] pat_lo_reg, pat_lo_next;
    logic [63:0] pat_hi_reg, pat_hi_next;
    logic [15:0] care_reg, care_next;
    logic [4:0]  length_reg, length_next;
    logic [63:0] base_reg, base_next;

    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic                   seen_reg, seen_next;

    pattern_cfg_t           cfg;
    logic [CW-1:0]          len_m1;
    logic                   accept;
    logic                   shift_en;
    logic                   clear_en;
    logic [7:0]             win [NCELL];
    logic [NCELL-1:0]       cell_ok;
    logic                   last_ok;
    logic                   hit;
    logic [OFFSET_BITS-1:0] start_off;
    logic                   push;
    result_t                push_data;
    result_t                head;
    logic                   wr_en;
    logic [2:0]             reg_idx;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        pat_lo_next = pat_lo_reg;
        pat_hi_next = pat_hi_reg;
        care_next   = care_reg;
        length_next = length_reg;
        base_next   = base_reg;
        if (wr_en)
        begin
            case (reg_idx)
                REG_PAT_LO: pat_lo_next = pwdata;
                REG_PAT_HI: pat_hi_next = pwdata;
                REG_CARE:   care_next   = pwdata[15:0];
                REG_LENGTH: length_next = pwdata[4:0];
                REG_BASE:   base_next   = pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PAT_LO: prdata = pat_lo_reg;
            REG_PAT_HI: prdata = pat_hi_reg;
            REG_CARE:   prdata = {48'h0, care_reg};
            REG_LENGTH: prdata = {59'h0, length_reg};
            REG_BASE:   prdata = base_reg;
            default:    prdata = 64'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= PAT_RESET;
            pat_hi_reg <= PAT_RESET;
            care_reg   <= CARE_RESET;
            length_reg <= LENGTH_RESET;
            base_reg   <= BASE_RESET;
        end
        else
        begin
            pat_lo_reg <= pat_lo_next;
            pat_hi_reg <= pat_hi_next;
            care_reg   <= care_next;
            length_reg <= length_next;
            base_reg   <= base_next;
        end
    end

    assign cfg.bytes = {pat_hi_reg, pat_lo_reg};
    assign cfg.care  = care_reg;

    // length in use minus one, clamped to the window size
    always_comb
    begin
        if (length_reg == 5'd0)
        begin
            len_m1 = '0;
        end
        else if (CW'(length_reg) > CW'(MAX_PATTERN))
        begin
            len_m1 = CW'(MAX_PATTERN - 1);
        end
        else
        begin
            len_m1 = CW'(length_reg) - CW'(1);
        end
    end

    // ---------------- window cells ----------------
    assign accept   = byte_valid && !byte_stall;
    assign shift_en = accept && !region_end;
    assign clear_en = accept && region_end;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        logic [7:0] cell_in;
        if (k == 0)
        begin : g_first
            assign cell_in = byte_value;
        end
        else
        begin : g_rest
            assign cell_in = win[k-1];
        end

        mbps_cell #(
            .K  (k),
            .CW (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (shift_en),
            .clear_en (clear_en),
            .byte_in  (cell_in),
            .cfg      (cfg),
            .len_m1   (len_m1),
            .byte_out (win[k]),
            .ok       (cell_ok[k])
        );
    end

    // newest byte against the last pattern position in use
    assign last_ok = pos_ok(cfg, len_m1[3:0], len_m1 >= CW'(PAT_BYTES), byte_value);

    assign hit = !seen_reg && (offset_reg >= OFFSET_BITS'(len_m1)) && last_ok && (&cell_ok);

    assign start_off = offset_reg - OFFSET_BITS'(len_m1);

    // ---------------- region state ----------------
    always_comb
    begin
        offset_next = offset_reg;
        seen_next   = seen_reg;
        if (accept)
        begin
            if (region_end)
            begin
                offset_next = '0;
                seen_next   = 1'b0;
            end
            else
            begin
                if (hit)
                begin
                    seen_next = 1'b1;
                end
                if (offset_reg != '1)
                begin
                    offset_next = offset_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            seen_reg   <= seen_next;
        end
    end

    // ---------------- result path ----------------
    assign push              = accept && (hit || (region_end && !seen_reg));
    assign push_data.found   = hit;
    assign push_data.address = hit ? (base_reg + ADDR_W'(start_off)) : '0;

    mbps_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_data    (push_data),
        .full         (byte_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign found         = head.found;
    assign match_address = head.address;

endmodule

`default_nettype wire

>>> design/mbps_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mbps_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        byte_stall,
    input wire logic        result_valid,
    input wire logic        result_stall,
    input wire logic        found,
    input wire logic [63:0] match_address
);

    // a waiting result is held until taken
    `MBPS_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
    `MBPS_ASSERT_NEXT(a_address_held, result_valid && result_stall, $stable(match_address))

    // not-found results carry a zero address
    `MBPS_ASSERT(a_not_found_zero, !result_valid || found || (match_address == 64'h0))

    // input only backs up once the output buffer holds a result
    `MBPS_ASSERT(a_stall_needs_result, !byte_stall || result_valid)

    // a stall on input means a result was waiting the cycle before
    `MBPS_ASSERT_NEXT(a_stall_from_output, !result_valid, !byte_stall)

endmodule

bind masked_byte_pattern_scanner_top mbps_checker u_mbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_stall    (byte_stall),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .found         (found),
    .match_address (match_address)
);

`default_nettype wire

>>> verif/mbps_result_checker.sv
`timescale 1ns / 100ps

module mbps_result_checker #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  byte_value,
    input  logic        region_end,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        found,
    input  logic [63:0] match_address,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          outstanding,
    output int          hits_seen,
    output int          misses_seen
);
    import mbps_pkg::*;

    // shadow of the register file
    logic [63:0]            pat_lo;
    logic [63:0]            pat_hi;
    logic [15:0]            care;
    logic [4:0]             len_reg;
    logic [63:0]            base;

    // window holds earlier bytes of the region, newest at index 0
    logic [7:0]             window [0:MAX_PATTERN-2];
    logic [OFFSET_BITS-1:0] offset;
    logic                   matched;

    result_t                awaited_results [$];
    result_t                oldest;
    int                     fail_total;
    int                     hit_total;
    int                     miss_total;

    initial
    begin
        fail_total = 0;
        hit_total  = 0;
        miss_total = 0;
    end

    task automatic flag_mismatch(input string what);
        fail_total++;
        $display("[%0t] scanner mismatch: %s", $realtime, what);
    endtask

    task automatic clear_region();
        for (int j = 0; j < MAX_PATTERN - 1; j++)
            window[j] = 8'h00;
        offset  = '0;
        matched = 1'b0;
    endtask

    function automatic int used_len();
        if (len_reg == 5'd0)
            return 1;
        if (int'(len_reg) > MAX_PATTERN)
            return MAX_PATTERN;
        return int'(len_reg);
    endfunction

    function automatic logic byte_agrees(input int j, input logic [7:0] d);
        logic [7:0] want;
        if (j >= 16)
            return 1'b1;
        if (!care[j])
            return 1'b1;
        want = (j < 8) ? pat_lo[8*j +: 8] : pat_hi[8*(j-8) +: 8];
        return want == d;
    endfunction

    // one accepted byte: look for the first match, then shift or clear
    task automatic take_byte(input logic [7:0] cur, input logic last);
        int      n;
        logic    hit;
        result_t r;
        n = used_len();
        if (!matched && offset >= OFFSET_BITS'(n - 1))
        begin
            hit = byte_agrees(n - 1, cur);
            for (int j = 0; j + 1 < n; j++)
                hit = hit && byte_agrees(j, window[n - 2 - j]);
            if (hit)
            begin
                matched   = 1'b1;
                r.found   = 1'b1;
                r.address = base + 64'(offset - OFFSET_BITS'(n - 1));
                awaited_results = {awaited_results, r};
                hit_total++;
            end
        end
        if (last)
        begin
            if (!matched)
            begin
                r.found   = 1'b0;
                r.address = '0;
                awaited_results = {awaited_results, r};
                miss_total++;
            end
            clear_region();
        end
        else
        begin
            for (int j = MAX_PATTERN - 2; j > 0; j--)
                window[j] = window[j - 1];
            window[0] = cur;
            if (offset != '1)
                offset++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo  = PAT_RESET;
            pat_hi  = PAT_RESET;
            care    = CARE_RESET;
            len_reg = LENGTH_RESET;
            base    = BASE_RESET;
            clear_region();
            awaited_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (awaited_results.size() == 0)
                    flag_mismatch($sformatf("result with nothing awaited: found=%0b addr=%h",
                                            found, match_address));
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (found !== oldest.found)
                        flag_mismatch($sformatf("found %0b, predicted %0b",
                                                found, oldest.found));
                    if (match_address !== oldest.address)
                        flag_mismatch($sformatf("match_address %h, predicted %h",
                                                match_address, oldest.address));
                end
            end
            if (byte_valid && !byte_stall)
                take_byte(byte_value, region_end);
            // a register write counts from the next byte on
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[5:3])
                    REG_PAT_LO: pat_lo  = pwdata;
                    REG_PAT_HI: pat_hi  = pwdata;
                    REG_CARE:   care    = pwdata[15:0];
                    REG_LENGTH: len_reg = pwdata[4:0];
                    REG_BASE:   base    = pwdata;
                    default:    ;
                endcase
            end
        end
        mismatches  <= fail_total;
        outstanding <= awaited_results.size();
        hits_seen   <= hit_total;
        misses_seen <= miss_total;
    end

endmodule

>>> verif/tb_masked_byte_pattern_scanner_top.sv
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner_top;
    import mbps_pkg::*;

    // an address past the register file, writes there must be ignored
    localparam logic [2:0] UNUSED_REG = 3'd5;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        byte_valid   = 1'b0;
    logic [7:0]  byte_value   = 8'h00;
    logic        region_end   = 1'b0;
    logic        result_stall = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [5:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;

    logic        byte_stall;
    logic        result_valid;
    logic        found;
    logic [63:0] match_address;
    logic [63:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          hits_seen;
    int          misses_seen;

    // stimulus-side copy of the registers, used to plant the pattern
    logic [63:0] cur_lo   = PAT_RESET;
    logic [63:0] cur_hi   = PAT_RESET;
    logic [15:0] cur_care = CARE_RESET;
    logic [4:0]  cur_len  = LENGTH_RESET;
    logic [63:0] cur_base = BASE_RESET;

    logic [7:0]  region_bytes [$];
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    int          items_sent    = 0;
    int          regions_sent  = 0;
    int          configs_used  = 1;
    int          phase_no      = 0;
    int          mode_start;

    masked_byte_pattern_scanner_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .region_end    (region_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .match_address (match_address),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mbps_result_checker i_scan_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_valid    (byte_valid),
        .byte_stall    (byte_stall),
        .byte_value    (byte_value),
        .region_end    (region_end),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .found         (found),
        .match_address (match_address),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .hits_seen     (hits_seen),
        .misses_seen   (misses_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        result_stall <= ($urandom_range(99) < sink_idle_pct);

    initial
    begin
        #3_000_000;
        $display("timeout: scanner run did not complete");
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic [63:0] base);
        apb_write(REG_PAT_LO, lo);
        apb_write(REG_PAT_HI, hi);
        apb_write(REG_CARE, 64'(care));
        apb_write(REG_LENGTH, 64'(len));
        apb_write(REG_BASE, base);
        cur_lo   = lo;
        cur_hi   = hi;
        cur_care = care;
        cur_len  = len;
        cur_base = base;
        configs_used++;
    endtask

    // one byte transfer, with a random gap ahead of it
    task automatic push_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_value <= value;
        region_end <= last;
        do @(posedge clk); while (byte_stall);
        items_sent++;
    endtask

    task automatic send_region();
        for (int i = 0; i < region_bytes.size(); i++)
            push_byte(region_bytes[i], i == region_bytes.size() - 1);
        regions_sent++;
    endtask

    // let every awaited result drain, then leave the inputs idle before going on
    task automatic settle();
        int guard;
        guard = 0;
        byte_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] planted_byte(input int j);
        if (!cur_care[j])
            return 8'($urandom);
        return (j < 8) ? cur_lo[8*j +: 8] : cur_hi[8*(j-8) +: 8];
    endfunction

    task automatic build_region();
        int n;
        int pick;
        int prefix;
        n = (cur_len == 5'd0) ? 1 : ((cur_len > 5'd16) ? 16 : int'(cur_len));
        pick = $urandom_range(99);
        region_bytes.delete();
        if (pick < 15)
        begin
            // plain noise
            repeat ($urandom_range(1, 24))
                region_bytes = {region_bytes, 8'($urandom)};
        end
        else if (pick < 25)
        begin
            // too short for the pattern to fit, unless the pattern is one byte long
            repeat ((n > 1) ? $urandom_range(1, n - 1) : 1)
                region_bytes = {region_bytes, 8'($urandom)};
        end
        else
        begin
            prefix = $urandom_range(0, 6);
            repeat (prefix)
                region_bytes = {region_bytes, 8'($urandom)};
            for (int j = 0; j < n; j++)
                region_bytes = {region_bytes, planted_byte(j)};
            // flip one byte of the copy, which breaks it where that byte is cared for
            if (pick < 45)
                region_bytes[prefix + $urandom_range(0, n - 1)] ^= 8'($urandom_range(1, 255));
            repeat ($urandom_range(0, 4))
                region_bytes = {region_bytes, 8'($urandom)};
        end
    endtask

    task automatic random_config();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] care;
        logic [4:0]  len;
        logic [63:0] base;
        lo   = {$urandom, $urandom};
        hi   = {$urandom, $urandom};
        care = 16'($urandom);
        base = {$urandom, $urandom};
        case (phase_no % 5)
            0:
            begin
                lo = '0;
                hi = '0;
            end
            1:
            begin
                lo = '1;
                hi = '1;
            end
            default: ;
        endcase
        case (phase_no % 4)
            0: care = '1;
            1: care = '0;
            2: care = care & 16'($urandom);
            default: ;
        endcase
        case (phase_no % 6)
            0: len = 5'd1;
            1: len = 5'd16;
            2: len = 5'd0;
            3: len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 8));
        endcase
        case (phase_no % 7)
            0: base = '0;
            1: base = '1;
            2: base = 64'hFFFF_FFFF_FFFF_FFFC;
            default: ;
        endcase
        set_config(lo, hi, care, len, base);
        phase_no++;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single-byte pattern 00, every position cared for
        region_bytes = '{8'h00};
        send_region();
        region_bytes = '{8'hFF};
        send_region();
        // later bytes after a match stay silent
        region_bytes = '{8'h55, 8'h00, 8'h00};
        send_region();
        settle();

        // full-length pattern, match finishing on the region's last byte
        apb_write(UNUSED_REG, '1);
        set_config(64'hFF00_7F80_A55A_3C01, 64'h00FF_0102_FEFD_C3E7, '1, 5'd16, '1);
        region_bytes.delete();
        for (int j = 0; j < 16; j++)
            region_bytes = {region_bytes, planted_byte(j)};
        send_region();
        region_bytes = '{planted_byte(0), planted_byte(1)};
        send_region();
        settle();

        // zero length behaves as one, everything wildcard
        set_config('0, '0, '0, 5'd0, '0);
        region_bytes = '{8'hA5};
        send_region();
        settle();

        for (int mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    src_idle_pct  = 12;
                    sink_idle_pct = 67;
                end
                1:
                begin
                    src_idle_pct  = 67;
                    sink_idle_pct = 12;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            mode_start = items_sent;
            while (items_sent - mode_start < 300)
            begin
                random_config();
                repeat ($urandom_range(4, 8))
                begin
                    build_region();
                    send_region();
                end
                settle();
            end
        end

        sink_idle_pct = 0;
        settle();
        repeat (8) @(posedge clk);

        $display("scanned %0d bytes in %0d regions under %0d register settings",
                 items_sent, regions_sent, configs_used);
        $display("predicted %0d matches and %0d misses, %0d still awaited",
                 hits_seen, misses_seen, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
